// ----- hw/rtl/aspect_locked_crop_window_core_defines.svh -----
// Assertion macros shared by the crop window RTL.
`ifndef ASPECT_LOCKED_CROP_WINDOW_CORE_DEFINES_SVH
`define ASPECT_LOCKED_CROP_WINDOW_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ALCW_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ALCW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/alcw_pkg.sv -----
// Types and constants of the aspect-locked crop window core.
package alcw_pkg;

    localparam int MAX_DIM   = 8192;
    localparam int FRAC_BITS = 16;

    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int POS_W  = 13;
    localparam int ROI_W  = 19;
    localparam int IDX_W  = 3;
    localparam int EXT_W  = FRAC_BITS + 1;
    localparam int CTR_W  = FRAC_BITS + 2;
    localparam int PROD_W = EXT_W + DIM_W;
    localparam int NUM1_W = PROD_W + 1;
    // Six guard bits: a widened extent at or above 2^(FRAC_BITS+6) always
    // rescales the other extent below the minimum.
    localparam int Q1_W   = FRAC_BITS + 6;
    localparam int NUM2_W = 2 * FRAC_BITS + 1;
    localparam int Q2_W   = FRAC_BITS + 1;
    localparam int PIX_W  = CTR_W + DIM_W + 1;

    localparam int ONE_Q   = 1 << FRAC_BITS;
    localparam int MIN_EXT = ((3 << FRAC_BITS) + 50) / 100;

    typedef enum logic [IDX_W-1:0] {
        REG_ZOOM_ENABLED = 3'd0,
        REG_ROI_LEFT     = 3'd1,
        REG_ROI_TOP      = 3'd2,
        REG_ROI_RIGHT    = 3'd3,
        REG_ROI_BOTTOM   = 3'd4
    } t_reg_idx;

    // Per-item context that travels down the pipeline from stage 2 to the output register.
    typedef struct packed {
        logic             byp;
        logic [DIM_W-1:0] fw;
        logic [DIM_W-1:0] fh;
        logic [CTR_W-1:0] xc2;
        logic [CTR_W-1:0] yc2;
    } t_ctx;

endpackage

// ----- hw/rtl/aspect_locked_crop_window_core.sv -----
// Aspect-locked crop window: frame size in, pixel crop rectangle out, fully pipelined.
// Registers from accept to o_valid: stages 1 to 3, both divider setups and chains, F1 to F4, output.
// Throughput: one frame size per cycle; the two radix-2 divider chains set the depth.
// busy is high only during reset; the result strobe o_valid lasts one cycle and cannot stall.
// Reset is synchronous, active low: it clears the valid bits and loads the register defaults.
`include "aspect_locked_crop_window_core_defines.svh"

module aspect_locked_crop_window_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [alcw_pkg::DIM_W-1:0]          i_frame_width,
    input  logic [alcw_pkg::DIM_W-1:0]          i_frame_height,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [alcw_pkg::IDX_W-1:0]          i_cfg_index,
    input  logic [alcw_pkg::ROI_W-1:0]          i_cfg_data,
    output logic                                o_valid,
    output logic [alcw_pkg::POS_W-1:0]          o_crop_x,
    output logic [alcw_pkg::POS_W-1:0]          o_crop_y,
    output logic [alcw_pkg::DIM_W-1:0]          o_crop_width,
    output logic [alcw_pkg::DIM_W-1:0]          o_crop_height,
    output logic                                o_is_full_frame
);

    localparam int DW   = alcw_pkg::DIM_W;
    localparam int EW   = alcw_pkg::EXT_W;
    localparam int CW   = alcw_pkg::CTR_W;
    localparam int RW   = alcw_pkg::ROI_W;
    localparam int PW   = alcw_pkg::PROD_W;
    localparam int N1W  = alcw_pkg::NUM1_W;
    localparam int Q1W  = alcw_pkg::Q1_W;
    localparam int N2W  = alcw_pkg::NUM2_W;
    localparam int Q2W  = alcw_pkg::Q2_W;
    localparam int XW   = alcw_pkg::PIX_W;
    localparam int FB   = alcw_pkg::FRAC_BITS;
    localparam int D1CW = DW + Q1W;
    localparam int D2CW = Q1W + Q2W;
    localparam int LATENCY = 10 + Q1W + Q2W;

    localparam logic [EW-1:0] ONE_E = EW'(alcw_pkg::ONE_Q);
    localparam logic [EW-1:0] MIN_E = EW'(alcw_pkg::MIN_EXT);
    localparam logic [DW-1:0] MAX_D = DW'(alcw_pkg::MAX_DIM);
    localparam logic [XW-1:0] CEIL_ADD = XW'((1 << (FB + 1)) - 1);

    // Clamp a signed corner to [0, 1.0].
    function automatic logic [EW-1:0] clamp_q(input logic signed [RW-1:0] v);
        if (v < 0)
            return '0;
        else if (v > $signed(RW'(alcw_pkg::ONE_Q)))
            return ONE_E;
        else
            return v[EW-1:0];
    endfunction

    function automatic logic [EW-1:0] ext_of(input logic [EW-1:0] lo, input logic [EW-1:0] hi);
        logic [EW-1:0] e;
        e = hi - lo;
        if (e < MIN_E)
            e = MIN_E;
        return e;
    endfunction

    function automatic logic [EW-1:0] org_of(input logic [EW-1:0] lo, input logic [EW-1:0] e);
        if (lo > ONE_E - e)
            return ONE_E - e;
        return lo;
    endfunction

    // Re-centered origin in half-LSB units, clamped to [0, 2*(1.0-ext)].
    function automatic logic [CW-1:0] recenter(input logic [CW-1:0] c2, input logic [EW-1:0] e);
        logic signed [CW:0] d;
        logic        [CW-1:0] lim;
        d   = $signed({1'b0, c2}) - $signed({2'b00, e});
        lim = CW'(ONE_E - e) << 1;
        if (d < 0)
            return '0;
        else if (d > $signed({1'b0, lim}))
            return lim;
        return d[CW-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers. Write them only while the pipeline is
    // empty; the block does not enforce it. Stage 1 reads them directly.
    // ------------------------------------------------------------------
    logic                 r_zoom_en;
    logic signed [RW-1:0] r_roi_l, r_roi_t, r_roi_r, r_roi_b;

    assign o_cfg_ready = i_rst_n;
    assign busy        = ~i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zoom_en <= 1'b0;
            r_roi_l   <= '0;
            r_roi_t   <= '0;
            r_roi_r   <= RW'(alcw_pkg::ONE_Q);
            r_roi_b   <= RW'(alcw_pkg::ONE_Q);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (alcw_pkg::t_reg_idx'(i_cfg_index))
                alcw_pkg::REG_ZOOM_ENABLED: r_zoom_en <= i_cfg_data[0];
                alcw_pkg::REG_ROI_LEFT:     r_roi_l   <= i_cfg_data;
                alcw_pkg::REG_ROI_TOP:      r_roi_t   <= i_cfg_data;
                alcw_pkg::REG_ROI_RIGHT:    r_roi_r   <= i_cfg_data;
                alcw_pkg::REG_ROI_BOTTOM:   r_roi_b   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: capture the transfer, saturate the frame size, and order
    // and clamp the corners of both axes. The enable is sampled here too,
    // so an item sees one consistent set of registers.
    // ------------------------------------------------------------------
    logic          r1_v;
    logic          r1_zen;
    logic [DW-1:0] r1_fw, r1_fh;
    logic [EW-1:0] r1_xlo, r1_xhi, r1_ylo, r1_yhi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r1_v <= 1'b0;
        else
            r1_v <= start && !busy;
        r1_zen <= r_zoom_en;
        r1_fw  <= (i_frame_width  > MAX_D) ? MAX_D : i_frame_width;
        r1_fh  <= (i_frame_height > MAX_D) ? MAX_D : i_frame_height;
        r1_xlo <= clamp_q((r_roi_l < r_roi_r) ? r_roi_l : r_roi_r);
        r1_xhi <= clamp_q((r_roi_l < r_roi_r) ? r_roi_r : r_roi_l);
        r1_ylo <= clamp_q((r_roi_t < r_roi_b) ? r_roi_t : r_roi_b);
        r1_yhi <= clamp_q((r_roi_t < r_roi_b) ? r_roi_b : r_roi_t);
    end

    // ------------------------------------------------------------------
    // Stage 2: extents with the minimum applied, origins kept inside the
    // frame, and the window center in half-LSB units.
    // ------------------------------------------------------------------
    logic          r2_v;
    alcw_pkg::t_ctx r2_ctx;
    logic [EW-1:0] r2_w, r2_h;
    logic [EW-1:0] n2_w, n2_h;

    assign n2_w = ext_of(r1_xlo, r1_xhi);
    assign n2_h = ext_of(r1_ylo, r1_yhi);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r2_v <= 1'b0;
        else
            r2_v <= r1_v;
        r2_w       <= n2_w;
        r2_h       <= n2_h;
        r2_ctx.byp <= !r1_zen || (r1_fw == '0) || (r1_fh == '0);
        r2_ctx.fw  <= r1_fw;
        r2_ctx.fh  <= r1_fh;
        r2_ctx.xc2 <= (CW'(org_of(r1_xlo, n2_w)) << 1) + CW'(n2_w);
        r2_ctx.yc2 <= (CW'(org_of(r1_ylo, n2_h)) << 1) + CW'(n2_h);
    end

    // ------------------------------------------------------------------
    // Stage 3: cross products that decide which extent gets widened.
    // ------------------------------------------------------------------
    logic          r3_v;
    alcw_pkg::t_ctx r3_ctx;
    logic [EW-1:0] r3_w, r3_h;
    logic [PW-1:0] r3_pw, r3_ph;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r3_v <= 1'b0;
        else
            r3_v <= r2_v;
        r3_ctx <= r2_ctx;
        r3_w   <= r2_w;
        r3_h   <= r2_h;
        r3_pw  <= PW'(r2_w) * PW'(r2_ctx.fh);
        r3_ph  <= PW'(r2_h) * PW'(r2_ctx.fw);
    end

    // ------------------------------------------------------------------
    // Stage 4: set up the first division. When swap is low the width is
    // kept and the height becomes w*fh/fw; when high the height is kept
    // and the width becomes h*fw/fh. Half the divisor is added first so
    // the quotient rounds half up. A quotient that does not fit in Q1W
    // bits is flagged as saturated.
    // ------------------------------------------------------------------
    logic              r_d1_v   [0:Q1W];
    alcw_pkg::t_ctx    r_d1_ctx [0:Q1W];
    logic              r_d1_s   [0:Q1W];
    logic              r_d1_ov  [0:Q1W];
    logic [EW-1:0]     r_d1_k   [0:Q1W];
    logic [DW-1:0]     r_d1_d   [0:Q1W];
    logic [N1W-1:0]    r_d1_rem [0:Q1W];
    logic [Q1W-1:0]    r_d1_q   [0:Q1W];

    logic              n4_s;
    logic [DW-1:0]     n4_d;
    logic [N1W-1:0]    n4_n;

    assign n4_s = !(r3_pw > r3_ph);
    assign n4_d = n4_s ? r3_ctx.fh : r3_ctx.fw;
    assign n4_n = N1W'(n4_s ? r3_ph : r3_pw) + N1W'(n4_d >> 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_d1_v[0] <= 1'b0;
        else
            r_d1_v[0] <= r3_v;
        r_d1_ctx[0] <= r3_ctx;
        r_d1_s[0]   <= n4_s;
        r_d1_k[0]   <= n4_s ? r3_h : r3_w;
        r_d1_d[0]   <= n4_d;
        r_d1_ov[0]  <= D1CW'(n4_n) >= (D1CW'(n4_d) << Q1W);
        r_d1_rem[0] <= n4_n;
        r_d1_q[0]   <= '0;
    end

    // First divider: one quotient bit per stage, most significant first.
    for (genvar j = 0; j < Q1W; j++) begin : g_div1
        localparam int SH = Q1W - 1 - j;
        logic [D1CW-1:0] trial;
        logic            ge;

        assign trial = D1CW'(r_d1_d[j]) << SH;
        assign ge    = D1CW'(r_d1_rem[j]) >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n)
                r_d1_v[j+1] <= 1'b0;
            else
                r_d1_v[j+1] <= r_d1_v[j];
            r_d1_ctx[j+1] <= r_d1_ctx[j];
            r_d1_s[j+1]   <= r_d1_s[j];
            r_d1_ov[j+1]  <= r_d1_ov[j];
            r_d1_k[j+1]   <= r_d1_k[j];
            r_d1_d[j+1]   <= r_d1_d[j];
            r_d1_rem[j+1] <= ge ? (r_d1_rem[j] - trial[N1W-1:0]) : r_d1_rem[j];
            r_d1_q[j+1]   <= r_d1_q[j] | (ge ? (Q1W'(1) << SH) : '0);
        end
    end

    // ------------------------------------------------------------------
    // Rescale setup: if the widened extent passed 1.0, the kept extent
    // becomes kept*1.0/widened (rounded half up) and the widened one 1.0.
    // ------------------------------------------------------------------
    logic              r_d2_v     [0:Q2W];
    alcw_pkg::t_ctx    r_d2_ctx   [0:Q2W];
    logic              r_d2_s     [0:Q2W];
    logic              r_d2_sat   [0:Q2W];
    logic              r_d2_big   [0:Q2W];
    logic [EW-1:0]     r_d2_k     [0:Q2W];
    logic [EW-1:0]     r_d2_small [0:Q2W];
    logic [Q1W-1:0]    r_d2_d     [0:Q2W];
    logic [N2W-1:0]    r_d2_rem   [0:Q2W];
    logic [Q2W-1:0]    r_d2_q     [0:Q2W];

    logic [Q1W-1:0]    np_q1;
    logic              np_over;

    assign np_q1   = r_d1_q[Q1W];
    assign np_over = np_q1 > Q1W'(alcw_pkg::ONE_Q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_d2_v[0] <= 1'b0;
        else
            r_d2_v[0] <= r_d1_v[Q1W];
        r_d2_ctx[0]   <= r_d1_ctx[Q1W];
        r_d2_s[0]     <= r_d1_s[Q1W];
        r_d2_sat[0]   <= r_d1_ov[Q1W];
        r_d2_big[0]   <= r_d1_ov[Q1W] || np_over;
        r_d2_k[0]     <= r_d1_k[Q1W];
        r_d2_small[0] <= np_q1[EW-1:0];
        r_d2_d[0]     <= np_q1;
        r_d2_rem[0]   <= (N2W'(r_d1_k[Q1W]) << FB) + N2W'(np_q1 >> 1);
        r_d2_q[0]     <= '0;
    end

    // Second divider, same scheme as the first.
    for (genvar j = 0; j < Q2W; j++) begin : g_div2
        localparam int SH = Q2W - 1 - j;
        logic [D2CW-1:0] trial;
        logic            ge;

        assign trial = D2CW'(r_d2_d[j]) << SH;
        assign ge    = D2CW'(r_d2_rem[j]) >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n)
                r_d2_v[j+1] <= 1'b0;
            else
                r_d2_v[j+1] <= r_d2_v[j];
            r_d2_ctx[j+1]   <= r_d2_ctx[j];
            r_d2_s[j+1]     <= r_d2_s[j];
            r_d2_sat[j+1]   <= r_d2_sat[j];
            r_d2_big[j+1]   <= r_d2_big[j];
            r_d2_k[j+1]     <= r_d2_k[j];
            r_d2_small[j+1] <= r_d2_small[j];
            r_d2_d[j+1]     <= r_d2_d[j];
            r_d2_rem[j+1]   <= ge ? (r_d2_rem[j] - trial[N2W-1:0]) : r_d2_rem[j];
            r_d2_q[j+1]     <= r_d2_q[j] | (ge ? (Q2W'(1) << SH) : '0);
        end
    end

    // ------------------------------------------------------------------
    // F1: final extents, clamped to [minimum, 1.0], mapped back to axes.
    // A saturated first quotient always rescales to the minimum.
    // ------------------------------------------------------------------
    logic           rf1_v;
    alcw_pkg::t_ctx rf1_ctx;
    logic [EW-1:0]  rf1_w, rf1_h;
    logic [EW-1:0]  nf1_kept, nf1_other;
    logic [Q2W-1:0] nf1_q2;

    assign nf1_q2 = r_d2_q[Q2W];

    always_comb begin
        if (r_d2_big[Q2W]) begin
            nf1_other = ONE_E;
            if (r_d2_sat[Q2W] || (nf1_q2 < Q2W'(MIN_E)))
                nf1_kept = MIN_E;
            else if (nf1_q2 > Q2W'(ONE_E))
                nf1_kept = ONE_E;
            else
                nf1_kept = nf1_q2[EW-1:0];
        end else begin
            nf1_kept  = r_d2_k[Q2W];
            nf1_other = (r_d2_small[Q2W] < MIN_E) ? MIN_E : r_d2_small[Q2W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            rf1_v <= 1'b0;
        else
            rf1_v <= r_d2_v[Q2W];
        rf1_ctx <= r_d2_ctx[Q2W];
        rf1_w   <= r_d2_s[Q2W] ? nf1_other : nf1_kept;
        rf1_h   <= r_d2_s[Q2W] ? nf1_kept : nf1_other;
    end

    // ------------------------------------------------------------------
    // F2: re-center on the ordered window's center, keep it inside the
    // frame, and form the far edge, all in half-LSB units.
    // ------------------------------------------------------------------
    logic           rf2_v;
    alcw_pkg::t_ctx rf2_ctx;
    logic [CW-1:0]  rf2_x0, rf2_x1, rf2_y0, rf2_y1;
    logic [CW-1:0]  nf2_x, nf2_y;

    assign nf2_x = recenter(rf1_ctx.xc2, rf1_w);
    assign nf2_y = recenter(rf1_ctx.yc2, rf1_h);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            rf2_v <= 1'b0;
        else
            rf2_v <= rf1_v;
        rf2_ctx <= rf1_ctx;
        rf2_x0  <= nf2_x;
        rf2_y0  <= nf2_y;
        rf2_x1  <= nf2_x + (CW'(rf1_w) << 1);
        rf2_y1  <= nf2_y + (CW'(rf1_h) << 1);
    end

    // ------------------------------------------------------------------
    // F3: scale the edges by the frame size.
    // ------------------------------------------------------------------
    logic           rf3_v;
    alcw_pkg::t_ctx rf3_ctx;
    logic [XW-1:0]  rf3_x0, rf3_x1, rf3_y0, rf3_y1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            rf3_v <= 1'b0;
        else
            rf3_v <= rf2_v;
        rf3_ctx <= rf2_ctx;
        rf3_x0  <= XW'(rf2_x0) * XW'(rf2_ctx.fw);
        rf3_x1  <= XW'(rf2_x1) * XW'(rf2_ctx.fw);
        rf3_y0  <= XW'(rf2_y0) * XW'(rf2_ctx.fh);
        rf3_y1  <= XW'(rf2_y1) * XW'(rf2_ctx.fh);
    end

    // ------------------------------------------------------------------
    // F4: floor the near edge and ceil the far edge to pixels, keeping at
    // least one pixel and staying within the frame.
    // ------------------------------------------------------------------
    logic           rf4_v;
    alcw_pkg::t_ctx rf4_ctx;
    logic [DW-1:0]  rf4_x0, rf4_x1, rf4_y0, rf4_y1;
    logic [DW-1:0]  nf4_x0, nf4_x1, nf4_y0, nf4_y1;
    logic [XW-1:0]  nf4_xc, nf4_yc;

    assign nf4_xc = (rf3_x1 + CEIL_ADD) >> (FB + 1);
    assign nf4_yc = (rf3_y1 + CEIL_ADD) >> (FB + 1);

    always_comb begin
        nf4_x0 = DW'(rf3_x0 >> (FB + 1));
        nf4_y0 = DW'(rf3_y0 >> (FB + 1));
        if (nf4_x0 > rf3_ctx.fw - 1'b1)
            nf4_x0 = rf3_ctx.fw - 1'b1;
        if (nf4_y0 > rf3_ctx.fh - 1'b1)
            nf4_y0 = rf3_ctx.fh - 1'b1;
        if (nf4_xc > XW'(rf3_ctx.fw))
            nf4_x1 = rf3_ctx.fw;
        else if (nf4_xc < XW'(nf4_x0) + 1'b1)
            nf4_x1 = nf4_x0 + 1'b1;
        else
            nf4_x1 = nf4_xc[DW-1:0];
        if (nf4_yc > XW'(rf3_ctx.fh))
            nf4_y1 = rf3_ctx.fh;
        else if (nf4_yc < XW'(nf4_y0) + 1'b1)
            nf4_y1 = nf4_y0 + 1'b1;
        else
            nf4_y1 = nf4_yc[DW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            rf4_v <= 1'b0;
        else
            rf4_v <= rf3_v;
        rf4_ctx <= rf3_ctx;
        rf4_x0  <= nf4_x0;
        rf4_x1  <= nf4_x1;
        rf4_y0  <= nf4_y0;
        rf4_y1  <= nf4_y1;
    end

    // ------------------------------------------------------------------
    // Output register. A disabled zoom or a zero dimension bypasses the
    // window and reports the full frame.
    // ------------------------------------------------------------------
    logic          r_out_v;
    logic [alcw_pkg::POS_W-1:0] r_out_x, r_out_y;
    logic [DW-1:0] r_out_w, r_out_h;
    logic          r_out_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_out_v <= 1'b0;
        else
            r_out_v <= rf4_v;
        if (rf4_ctx.byp) begin
            r_out_x    <= '0;
            r_out_y    <= '0;
            r_out_w    <= rf4_ctx.fw;
            r_out_h    <= rf4_ctx.fh;
            r_out_full <= 1'b1;
        end else begin
            r_out_x    <= rf4_x0[alcw_pkg::POS_W-1:0];
            r_out_y    <= rf4_y0[alcw_pkg::POS_W-1:0];
            r_out_w    <= rf4_x1 - rf4_x0;
            r_out_h    <= rf4_y1 - rf4_y0;
            r_out_full <= (rf4_x0 == '0) && (rf4_y0 == '0) &&
                          (rf4_x1 == rf4_ctx.fw) && (rf4_y1 == rf4_ctx.fh);
        end
    end

    assign o_valid         = r_out_v;
    assign o_crop_x        = r_out_x;
    assign o_crop_y        = r_out_y;
    assign o_crop_width    = r_out_w;
    assign o_crop_height   = r_out_h;
    assign o_is_full_frame = r_out_full;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `ALCW_ASSERT_SAME(a_result_has_transfer, i_clk, i_rst_n, o_valid, $past(start && !busy, LATENCY), "result without a matching input transfer")
    `ALCW_ASSERT_SAME(a_window_not_empty, i_clk, i_rst_n, o_valid && !o_is_full_frame, (o_crop_width != '0) && (o_crop_height != '0), "zoom window came out empty")
    `ALCW_ASSERT_NEXT(a_enable_written, i_clk, i_rst_n, i_cfg_valid && o_cfg_ready && (i_cfg_index == alcw_pkg::REG_ZOOM_ENABLED), r_zoom_en == $past(i_cfg_data[0]), "zoom enable write lost")

endmodule

// ----- bench/aspect_locked_crop_window_core_test.sv -----
// Self-checking testbench of the aspect-locked crop window core.
`timescale 1ns / 1ps

module aspect_locked_crop_window_core_test;
    import alcw_pkg::*;

    // Writes to this index land on no register and must be ignored.
    localparam logic [IDX_W-1:0] IDX_UNMAPPED = 3'd5;
    // Cycles allowed to pass after the last result before a register write or the end.
    localparam int SETTLE_CYCLES = 60;
    // Cycles without any transfer after which the run is declared hung.
    localparam int HANG_LIMIT = 2000;

    // One crop rectangle as the block reports it.
    typedef struct {
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        logic             full;
    } t_crop;

    // Holds a copy of the window registers, predicts the crop rectangle of each
    // accepted frame size and checks the results in order.
    class crop_scoreboard;
        logic              zoom;
        logic [ROI_W-1:0]  left, top, right, bottom;
        t_crop             crops_due[$];
        int                errors;

        function new();
            zoom   = 1'b0;
            left   = '0;
            top    = '0;
            right  = ROI_W'(ONE_Q);
            bottom = ROI_W'(ONE_Q);
            errors = 0;
        endfunction

        function void write_reg(logic [IDX_W-1:0] idx, logic [ROI_W-1:0] data);
            case (idx)
                REG_ZOOM_ENABLED: zoom   = data[0];
                REG_ROI_LEFT:     left   = data;
                REG_ROI_TOP:      top    = data;
                REG_ROI_RIGHT:    right  = data;
                REG_ROI_BOTTOM:   bottom = data;
                default: ;
            endcase
        endfunction

        function int pending();
            return crops_due.size();
        endfunction

        function longint clip(longint v, longint lo, longint hi);
            if (v > hi) v = hi;
            if (v < lo) v = lo;
            return v;
        endfunction

        // Division rounded half up; numerator non-negative.
        function longint div_round(longint n, longint d);
            return (n + d / 2) / d;
        endfunction

        // Orders two corners, clamps them to [0,1] and holds the minimum extent.
        function void span_of(logic [ROI_W-1:0] ra, logic [ROI_W-1:0] rb,
                              output longint org, output longint ext);
            longint a, b, lo, hi;
            a   = longint'($signed(ra));
            b   = longint'($signed(rb));
            lo  = clip(a < b ? a : b, 0, ONE_Q);
            hi  = clip(a < b ? b : a, 0, ONE_Q);
            ext = clip(hi - lo, MIN_EXT, ONE_Q);
            org = clip(lo, 0, ONE_Q - ext);
        endfunction

        // The origin comes in half-LSB units; left edge floors, right edge ceils.
        function void pixel_edges(longint org2, longint ext, longint dim,
                                  output longint p0, output longint p1);
            longint den;
            den = 2 * ONE_Q;
            p0  = (org2 * dim) / den;
            p1  = ((org2 + 2 * ext) * dim + den - 1) / den;
            p0  = clip(p0, 0, dim - 1);
            p1  = clip(p1, p0 + 1, dim);
        endfunction

        function void note_frame(logic [DIM_W-1:0] fw_in, logic [DIM_W-1:0] fh_in);
            longint fw, fh, x, y, w, h, x2, y2, x0, x1, y0, y1;
            t_crop  c;
            fw = (fw_in > MAX_DIM) ? MAX_DIM : fw_in;
            fh = (fh_in > MAX_DIM) ? MAX_DIM : fh_in;
            if (!zoom || fw == 0 || fh == 0) begin
                c.x = '0;
                c.y = '0;
                c.w = DIM_W'(fw);
                c.h = DIM_W'(fh);
                c.full = 1'b1;
            end else begin
                span_of(left, right, x, w);
                span_of(top, bottom, y, h);
                // Centers are kept doubled so the halving is exact.
                x2 = 2 * x + w;
                y2 = 2 * y + h;
                if (w * fh > h * fw) h = div_round(w * fh, fw);
                else                 w = div_round(h * fw, fh);
                if (w > ONE_Q || h > ONE_Q) begin
                    if (w >= h) begin
                        h = div_round(h * ONE_Q, w);
                        w = ONE_Q;
                    end else begin
                        w = div_round(w * ONE_Q, h);
                        h = ONE_Q;
                    end
                end
                w  = clip(w, MIN_EXT, ONE_Q);
                h  = clip(h, MIN_EXT, ONE_Q);
                x2 = clip(x2 - w, 0, 2 * (ONE_Q - w));
                y2 = clip(y2 - h, 0, 2 * (ONE_Q - h));
                pixel_edges(x2, w, fw, x0, x1);
                pixel_edges(y2, h, fh, y0, y1);
                c.x = POS_W'(x0);
                c.y = POS_W'(y0);
                c.w = DIM_W'(x1 - x0);
                c.h = DIM_W'(y1 - y0);
                c.full = (x0 == 0 && y0 == 0 && x1 == fw && y1 == fh);
            end
            crops_due.push_back(c);
        endfunction

        function void check_crop(t_crop got);
            t_crop want;
            if (crops_due.size() == 0) begin
                $error("crop result with no frame size waiting");
                errors++;
                return;
            end
            want = crops_due.pop_front();
            if (got.x !== want.x) begin
                $error("crop_x expected %0d actual %0d", want.x, got.x);
                errors++;
            end
            if (got.y !== want.y) begin
                $error("crop_y expected %0d actual %0d", want.y, got.y);
                errors++;
            end
            if (got.w !== want.w) begin
                $error("crop_width expected %0d actual %0d", want.w, got.w);
                errors++;
            end
            if (got.h !== want.h) begin
                $error("crop_height expected %0d actual %0d", want.h, got.h);
                errors++;
            end
            if (got.full !== want.full) begin
                $error("is_full_frame expected %0d actual %0d", want.full, got.full);
                errors++;
            end
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [DIM_W-1:0]  i_frame_width;
    logic [DIM_W-1:0]  i_frame_height;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [IDX_W-1:0]  i_cfg_index;
    logic [ROI_W-1:0]  i_cfg_data;
    logic              o_valid;
    logic [POS_W-1:0]  o_crop_x;
    logic [POS_W-1:0]  o_crop_y;
    logic [DIM_W-1:0]  o_crop_width;
    logic [DIM_W-1:0]  o_crop_height;
    logic              o_is_full_frame;

    crop_scoreboard sb;
    int             quiet_cycles;

    aspect_locked_crop_window_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_frame_width   (i_frame_width),
        .i_frame_height  (i_frame_height),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_valid         (o_valid),
        .o_crop_x        (o_crop_x),
        .o_crop_y        (o_crop_y),
        .o_crop_width    (o_crop_width),
        .o_crop_height   (o_crop_height),
        .o_is_full_frame (o_is_full_frame)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Everything is sampled at the rising edge; the drivers only move signals at
    // the falling edge, so the sampled values are settled. Each transfer of a
    // frame size feeds the predictor and each result strobe is checked. The
    // watchdog restarts on any transfer and ends a run that has stopped moving.
    always @(posedge i_clk) begin
        t_crop got;
        bit    moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (start && !busy) begin
                sb.note_frame(i_frame_width, i_frame_height);
                moved = 1'b1;
            end
            if (i_cfg_valid && o_cfg_ready) moved = 1'b1;
            if (o_valid) begin
                got.x    = o_crop_x;
                got.y    = o_crop_y;
                got.w    = o_crop_width;
                got.h    = o_crop_height;
                got.full = o_is_full_frame;
                sb.check_crop(got);
                moved = 1'b1;
            end
            quiet_cycles <= moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= HANG_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Writes one register through the configuration channel, then records it.
    task automatic write_reg(logic [IDX_W-1:0] idx, logic [ROI_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_window(int l, int t, int r, int b);
        write_reg(REG_ROI_LEFT,   ROI_W'(l));
        write_reg(REG_ROI_TOP,    ROI_W'(t));
        write_reg(REG_ROI_RIGHT,  ROI_W'(r));
        write_reg(REG_ROI_BOTTOM, ROI_W'(b));
    endtask

    // Offers one frame size, possibly after a short idle burst, and holds it
    // until the block takes it. start stays high between back-to-back items.
    task automatic send_frame(int fw, int fh, bit gaps);
        if (gaps && $urandom_range(3) == 0) begin
            repeat ($urandom_range(1, 4)) begin
                @(negedge i_clk);
                start <= 1'b0;
            end
        end
        @(negedge i_clk);
        start          <= 1'b1;
        i_frame_width  <= DIM_W'(fw);
        i_frame_height <= DIM_W'(fh);
        do @(posedge i_clk); while (busy);
    endtask

    // Lowers start and waits until every predicted rectangle has come back.
    task automatic drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Mostly legal sizes, a share of tiny ones, plus zeros and oversized values
    // so that every input bit toggles.
    function automatic int pick_dim();
        int m;
        m = $urandom_range(9);
        if (m == 0) return 0;
        if (m == 1) return $urandom_range(16383, MAX_DIM + 1);
        if (m < 5)  return $urandom_range(64, 1);
        return $urandom_range(MAX_DIM, 1);
    endfunction

    // A corner: mostly inside the frame, sometimes anywhere from -1.0 to 2.0.
    function automatic int pick_corner();
        if ($urandom_range(4) == 0) return int'($urandom_range(196608)) - 65536;
        return $urandom_range(ONE_Q);
    endfunction

    task automatic random_frames(int n, bit gaps);
        repeat (n) send_frame(pick_dim(), pick_dim(), gaps);
    endtask

    initial begin
        int c;
        sb             = new();
        quiet_cycles   = 0;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_frame_width  = '0;
        i_frame_height = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = REG_ZOOM_ENABLED;
        i_cfg_data     = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Zoom off after reset: full frame; zeros pass through and oversized sizes saturate to MAX_DIM.
        send_frame(0, 0, 0);
        send_frame(0, 77, 0);
        send_frame(640, 0, 0);
        send_frame(MAX_DIM, MAX_DIM, 0);
        send_frame(16383, 16383, 0);
        send_frame(MAX_DIM + 1, 1, 0);
        send_frame(1920, 1080, 1);
        drain();

        // Zoom on over the reset window, which covers the whole frame.
        write_reg(REG_ZOOM_ENABLED, 19'h7FFFF);
        send_frame(1, 1, 0);
        send_frame(1920, 1080, 0);
        send_frame(1, MAX_DIM, 0);
        send_frame(MAX_DIM, 1, 0);
        send_frame(16383, 5, 0);
        send_frame(0, 300, 0);
        drain();

        // Swapped corners far outside [0,1]; ordering then clamping gives the frame.
        set_window(131072, -65536, -65536, 131072);
        send_frame(1280, 720, 0);
        send_frame(3, 4000, 0);
        drain();

        // Degenerate window, at the far edge vertically: minimum extent, shifted back inside.
        // A write to an unmapped index must leave the window alone.
        set_window(30000, ONE_Q, 30000, ONE_Q);
        write_reg(IDX_UNMAPPED, 19'h00123);
        send_frame(1920, 1080, 0);
        send_frame(MAX_DIM, MAX_DIM, 0);
        send_frame(7, 8000, 0);
        send_frame(2, 2, 0);
        drain();

        // Random windows, one phase each. One phase turns the zoom back off, and
        // one stops the sender midway until every result has returned.
        for (int ph = 0; ph < 12; ph++) begin
            c = pick_corner();
            if (ph % 3 == 2) set_window(c, pick_corner(), c + $urandom_range(3000),
                                        pick_corner());
            else             set_window(pick_corner(), pick_corner(), pick_corner(),
                                        pick_corner());
            write_reg(REG_ZOOM_ENABLED, (ph == 5) ? 19'h7FFFE : 19'h00001);
            random_frames(25, ph % 4 != 3);
            if (ph == 7) drain();
            random_frames(25, ph % 4 != 3);
            drain();
        end

        // Closing stretch: back-to-back items with no idling.
        set_window(12000, 5000, 40000, 9000);
        random_frames(40, 0);
        drain();

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
